// ===== sv/rdc_pkg.sv =====
// ----------------------------------------------------------------------------
// Reel depth controller package
// Shared types, codes, reset values and the control store of the sequencer.
// ----------------------------------------------------------------------------
package rdc_pkg;

   localparam int PcWidth  = 5;
   localparam int DivSteps = 15;

   typedef logic [PcWidth-1:0] pc_type;

   typedef enum logic [1:0] {
      REQ_TICK,
      REQ_CLICK,
      REQ_SWITCH,
      REQ_PWM
   } req_kind_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_TICK_INC,
      OP_TICK_ROLL,
      OP_DIV_START,
      OP_SET_UP,
      OP_SET_DOWN,
      OP_SET_STOP,
      OP_SET_TIMEOUT,
      OP_CLICK_STEP,
      OP_CLICK_CHECK,
      OP_SWITCH,
      OP_PWM_EDGE,
      OP_PWM_ARM,
      OP_PUBLISH
   } op_type;

   typedef enum logic [2:0] {
      CND_NEVER,
      CND_ALWAYS,
      CND_TIMEOUT,
      CND_HOLD,
      CND_BELOW,
      CND_DIV_BUSY
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      pc_type   target;
      logic     last;
   } uword_type;

   typedef struct packed {
      logic timeout_over;
      logic hold;
      logic below;
      logic div_busy;
   } dp_status_type;

   localparam logic [1:0] DIR_STOP = 2'd0;
   localparam logic [1:0] DIR_UP   = 2'd1;
   localparam logic [1:0] DIR_DOWN = 2'd2;

   localparam logic [2:0] EVT_NONE      = 3'd0;
   localparam logic [2:0] EVT_HOMED     = 3'd1;
   localparam logic [2:0] EVT_LIMIT_ERR = 3'd2;
   localparam logic [2:0] EVT_BOUNDS    = 3'd3;
   localparam logic [2:0] EVT_ARMED     = 3'd4;

   localparam logic [2:0] TRS_IDLE    = 3'd0;
   localparam logic [2:0] TRS_UP      = 3'd1;
   localparam logic [2:0] TRS_DOWN    = 3'd2;
   localparam logic [2:0] TRS_TIMEOUT = 3'd3;
   localparam logic [2:0] TRS_SWITCH  = 3'd4;

   localparam logic [2:0] CSR_TICK_LIMIT      = 3'd0;
   localparam logic [2:0] CSR_TIMEOUT_LIMIT   = 3'd1;
   localparam logic [2:0] CSR_DUTY_LOW        = 3'd2;
   localparam logic [2:0] CSR_DUTY_HIGH       = 3'd3;
   localparam logic [2:0] CSR_DUTY_NEUTRAL    = 3'd4;
   localparam logic [2:0] CSR_CLICKS_PER_WRAP = 3'd5;
   localparam logic [2:0] CSR_DEPTH_MAX       = 3'd6;
   localparam logic [2:0] CSR_HOME_WINDOW     = 3'd7;

   localparam logic [14:0] DEPTH_TOP = 15'h7FFF;

   typedef struct packed {
      logic [15:0] tick_limit;
      logic [15:0] timeout_limit;
      logic [15:0] duty_low;
      logic [15:0] duty_high;
      logic [15:0] duty_neutral;
      logic [14:0] clicks_per_wrap;
      logic [14:0] depth_max;
      logic [14:0] home_window;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      tick_limit:      16'd60000,
      timeout_limit:   16'd10,
      duty_low:        16'd2000,
      duty_high:       16'd4000,
      duty_neutral:    16'd3000,
      clicks_per_wrap: 15'd10,
      depth_max:       15'd1000,
      home_window:     15'd10
   };

   typedef struct packed {
      logic [14:0] depth;
      logic [1:0]  dir;
      logic        run;
      logic        stop;
      logic [15:0] tick;
      logic [15:0] tmo;
      logic [15:0] rise;
      logic [15:0] width;
      logic [2:0]  last_evt;
      logic [15:0] motor;
      logic [15:0] wind;
      logic [2:0]  tres;
   } state_type;

   localparam state_type STATE_RESET = '{
      depth:    15'd0,
      dir:      DIR_STOP,
      run:      1'b0,
      stop:     1'b1,
      tick:     16'd0,
      tmo:      16'd0,
      rise:     16'd0,
      width:    16'd0,
      last_evt: EVT_NONE,
      motor:    16'd0,
      wind:     16'd0,
      tres:     TRS_IDLE
   };

   typedef struct packed {
      logic [15:0] motor_duty;
      logic [15:0] wind_duty;
      logic [1:0]  direction;
      logic        all_stop;
      logic [2:0]  event_code;
      logic [2:0]  tick_result;
      logic [14:0] depth;
      logic [15:0] pulse_width;
   } rsp_word_type;

   localparam pc_type A_TICK   = 5'd0;
   localparam pc_type A_WAIT   = 5'd6;
   localparam pc_type A_DOWN   = 5'd8;
   localparam pc_type A_STOP   = 5'd9;
   localparam pc_type A_TMO    = 5'd10;
   localparam pc_type A_CLICK  = 5'd11;
   localparam pc_type A_SWITCH = 5'd13;
   localparam pc_type A_PWM    = 5'd14;
   localparam pc_type A_PUB    = 5'd16;

   function automatic uword_type uw(op_type op, cond_type cond, pc_type target, logic last);
      uword_type w;
      w.op     = op;
      w.cond   = cond;
      w.target = target;
      w.last   = last;
      return w;
   endfunction

   function automatic uword_type ucode_rom(pc_type pc);
      uword_type w;
      case (pc)
         5'd0:    w = uw(OP_TICK_INC,    CND_NEVER,    A_PUB,  1'b0);
         5'd1:    w = uw(OP_TICK_ROLL,   CND_NEVER,    A_PUB,  1'b0);
         5'd2:    w = uw(OP_NOP,         CND_TIMEOUT,  A_TMO,  1'b0);
         5'd3:    w = uw(OP_NOP,         CND_HOLD,     A_STOP, 1'b0);
         5'd4:    w = uw(OP_NOP,         CND_BELOW,    A_DOWN, 1'b0);
         5'd5:    w = uw(OP_DIV_START,   CND_NEVER,    A_PUB,  1'b0);
         5'd6:    w = uw(OP_NOP,         CND_DIV_BUSY, A_WAIT, 1'b0);
         5'd7:    w = uw(OP_SET_UP,      CND_ALWAYS,   A_PUB,  1'b0);
         5'd8:    w = uw(OP_SET_DOWN,    CND_ALWAYS,   A_PUB,  1'b0);
         5'd9:    w = uw(OP_SET_STOP,    CND_ALWAYS,   A_PUB,  1'b0);
         5'd10:   w = uw(OP_SET_TIMEOUT, CND_ALWAYS,   A_PUB,  1'b0);
         5'd11:   w = uw(OP_CLICK_STEP,  CND_NEVER,    A_PUB,  1'b0);
         5'd12:   w = uw(OP_CLICK_CHECK, CND_ALWAYS,   A_PUB,  1'b0);
         5'd13:   w = uw(OP_SWITCH,      CND_ALWAYS,   A_PUB,  1'b0);
         5'd14:   w = uw(OP_PWM_EDGE,    CND_NEVER,    A_PUB,  1'b0);
         5'd15:   w = uw(OP_PWM_ARM,     CND_NEVER,    A_PUB,  1'b0);
         5'd16:   w = uw(OP_PUBLISH,     CND_NEVER,    A_PUB,  1'b1);
         default: w = uw(OP_PUBLISH,     CND_NEVER,    A_PUB,  1'b1);
      endcase
      return w;
   endfunction

   function automatic pc_type entry_addr(logic [1:0] kind);
      pc_type a;
      case (kind)
         REQ_TICK:   a = A_TICK;
         REQ_CLICK:  a = A_CLICK;
         REQ_SWITCH: a = A_SWITCH;
         REQ_PWM:    a = A_PWM;
         default:    a = A_PUB;
      endcase
      return a;
   endfunction

endpackage

// ===== sv/rdc_ifs.sv =====
// ----------------------------------------------------------------------------
// Reel depth controller channels
// Valid/ready channels for request words, response words and register writes.
// ----------------------------------------------------------------------------
interface rdc_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic signed [15:0] target_click;
   logic               switch_open;
   logic               pin_level;
   logic [15:0]        timer_count;

   modport source (output valid, req_type, target_click, switch_open, pin_level,
                   timer_count, input ready);
   modport sink   (input valid, req_type, target_click, switch_open, pin_level,
                   timer_count, output ready);
endinterface

interface rdc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] motor_duty;
   logic [15:0] wind_duty;
   logic [1:0]  direction;
   logic        all_stop;
   logic [2:0]  event_code;
   logic [2:0]  tick_result;
   logic [14:0] depth;
   logic [15:0] pulse_width;

   modport source (output valid, motor_duty, wind_duty, direction, all_stop,
                   event_code, tick_result, depth, pulse_width, input ready);
   modport sink   (input valid, motor_duty, wind_duty, direction, all_stop,
                   event_code, tick_result, depth, pulse_width, output ready);
endinterface

interface rdc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/rdc_div.sv =====
// ----------------------------------------------------------------------------
// Reel depth controller divider
// Restoring divider, one quotient bit a cycle; gives the quotient parity.
// ----------------------------------------------------------------------------
module rdc_div
   import rdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [14:0] dividend,
   input  logic [14:0] divisor,
   output logic        busy,
   output logic        quo_odd
);

   logic        busy_ff, busy_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [14:0] rem_ff, rem_in;
   logic [14:0] quo_ff, quo_in;
   logic [14:0] dsr_ff, dsr_in;
   logic [15:0] partial;
   logic [16:0] diff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      partial = {rem_ff, quo_ff[14]};
      diff    = {1'b0, partial} - {2'b00, dsr_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = (divisor == '0) ? 15'd1 : divisor;
      end else if (busy_ff) begin
         if (!diff[16]) begin
            rem_in = diff[14:0];
            quo_in = {quo_ff[13:0], 1'b1};
         end else begin
            rem_in = partial[14:0];
            quo_in = {quo_ff[13:0], 1'b0};
         end
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'(DivSteps - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign busy    = busy_ff;
   assign quo_odd = quo_ff[0];

endmodule

// ===== sv/rdc_dp.sv =====
// ----------------------------------------------------------------------------
// Reel depth controller datapath
// Register file, reel state and response register, driven by control words.
// ----------------------------------------------------------------------------
module rdc_dp
   import rdc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic signed [15:0] target_click,
   input  logic               switch_open,
   input  logic               pin_level,
   input  logic [15:0]        timer_count,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data,
   input  op_type             op,
   output dp_status_type      status,
   output rsp_word_type       rsp_word
);

   cfg_type            cfg_ff, cfg_in;
   state_type          st_ff, st_in;
   rsp_word_type       rsp_ff, rsp_in;
   logic signed [15:0] target_ff;
   logic               sw_open_ff;
   logic               rising_ff;
   logic [15:0]        timer_ff;
   logic signed [15:0] depth_s;
   logic               div_start;
   logic               div_busy;
   logic               quo_odd;

   rdc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (st_ff.depth),
      .divisor  (cfg_ff.clicks_per_wrap),
      .busy     (div_busy),
      .quo_odd  (quo_odd)
   );

   assign depth_s   = signed'({1'b0, st_ff.depth});
   assign div_start = (op == OP_DIV_START);

   always_comb begin
      status.timeout_over = st_ff.tmo > cfg_ff.timeout_limit;
      status.hold         = (depth_s == target_ff) || !sw_open_ff;
      status.below        = depth_s < target_ff;
      status.div_busy     = div_busy;
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_TICK_LIMIT:      cfg_in.tick_limit      = csr_data;
            CSR_TIMEOUT_LIMIT:   cfg_in.timeout_limit   = csr_data;
            CSR_DUTY_LOW:        cfg_in.duty_low        = csr_data;
            CSR_DUTY_HIGH:       cfg_in.duty_high       = csr_data;
            CSR_DUTY_NEUTRAL:    cfg_in.duty_neutral    = csr_data;
            CSR_CLICKS_PER_WRAP: cfg_in.clicks_per_wrap = csr_data[14:0];
            CSR_DEPTH_MAX:       cfg_in.depth_max       = csr_data[14:0];
            CSR_HOME_WINDOW:     cfg_in.home_window     = csr_data[14:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      st_in = st_ff;
      if (accept) begin
         st_in.tres = TRS_IDLE;
      end
      case (op)
         OP_TICK_INC: begin
            st_in.tick = st_ff.tick + 16'd1;
         end
         OP_TICK_ROLL: begin
            if (st_ff.tick > cfg_ff.tick_limit) begin
               st_in.tick = '0;
               if (st_ff.tmo != 16'hFFFF) begin
                  st_in.tmo = st_ff.tmo + 16'd1;
               end
            end
         end
         OP_SET_UP: begin
            st_in.dir   = DIR_UP;
            st_in.motor = cfg_ff.duty_low;
            st_in.wind  = quo_odd ? cfg_ff.duty_high : cfg_ff.duty_low;
            st_in.tres  = TRS_UP;
         end
         OP_SET_DOWN: begin
            st_in.dir   = DIR_DOWN;
            st_in.motor = cfg_ff.duty_high;
            st_in.wind  = st_ff.stop ? 16'd0 : cfg_ff.duty_low;
            st_in.tres  = TRS_DOWN;
         end
         OP_SET_STOP: begin
            st_in.dir   = DIR_STOP;
            st_in.run   = 1'b0;
            st_in.motor = cfg_ff.duty_neutral;
            st_in.wind  = '0;
            st_in.stop  = 1'b1;
            if (sw_open_ff) begin
               st_in.tres = TRS_IDLE;
            end else begin
               st_in.last_evt = EVT_LIMIT_ERR;
               st_in.tres     = TRS_SWITCH;
            end
         end
         OP_SET_TIMEOUT: begin
            st_in.stop = 1'b1;
            st_in.tres = TRS_TIMEOUT;
         end
         OP_CLICK_STEP: begin
            if (st_ff.run && st_ff.dir == DIR_DOWN && st_ff.depth != DEPTH_TOP) begin
               st_in.depth = st_ff.depth + 15'd1;
            end else if (st_ff.run && st_ff.dir == DIR_UP && st_ff.depth != '0) begin
               st_in.depth = st_ff.depth - 15'd1;
            end
         end
         OP_CLICK_CHECK: begin
            if (st_ff.depth > cfg_ff.depth_max) begin
               st_in.stop     = 1'b1;
               st_in.run      = 1'b0;
               st_in.last_evt = EVT_BOUNDS;
            end
            st_in.tick = '0;
            st_in.tmo  = '0;
         end
         OP_SWITCH: begin
            if (st_ff.dir == DIR_UP && st_ff.run && st_ff.depth < cfg_ff.home_window) begin
               st_in.depth    = '0;
               st_in.dir      = DIR_STOP;
               st_in.last_evt = EVT_HOMED;
            end else begin
               st_in.last_evt = EVT_LIMIT_ERR;
            end
            st_in.run  = 1'b0;
            st_in.stop = 1'b1;
         end
         OP_PWM_EDGE: begin
            if (rising_ff) begin
               st_in.rise = timer_ff;
            end else begin
               st_in.width = timer_ff - st_ff.rise;
            end
         end
         OP_PWM_ARM: begin
            if (st_ff.width > cfg_ff.duty_neutral) begin
               st_in.run      = 1'b1;
               st_in.stop     = 1'b0;
               st_in.last_evt = EVT_ARMED;
            end
         end
         default: begin
            st_in.depth = st_ff.depth;
         end
      endcase
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (op == OP_PUBLISH) begin
         rsp_in.motor_duty  = st_ff.motor;
         rsp_in.wind_duty   = st_ff.wind;
         rsp_in.direction   = st_ff.dir;
         rsp_in.all_stop    = st_ff.stop;
         rsp_in.event_code  = st_ff.last_evt;
         rsp_in.tick_result = st_ff.tres;
         rsp_in.depth       = st_ff.depth;
         rsp_in.pulse_width = st_ff.width;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
         st_ff  <= STATE_RESET;
      end else begin
         cfg_ff <= cfg_in;
         st_ff  <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (accept) begin
         target_ff  <= target_click;
         sw_open_ff <= switch_open;
         rising_ff  <= pin_level;
         timer_ff   <= timer_count;
      end
   end

   assign rsp_word = rsp_ff;

endmodule

// ===== sv/rdc_useq.sv =====
// ----------------------------------------------------------------------------
// Reel depth controller sequencer
// Step counter over the control store with conditional jumps and dispatch.
// ----------------------------------------------------------------------------
module rdc_useq
   import rdc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_kind,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output logic          req_ready,
   output logic          rsp_valid,
   output logic          accept,
   output op_type        op
);

   logic      busy_ff, busy_in;
   pc_type    pc_ff, pc_in;
   logic      rsp_valid_ff, rsp_valid_in;
   uword_type word;
   logic      stall;
   logic      step;
   logic      jump;

   assign req_ready = !busy_ff;
   assign accept    = req_valid && !busy_ff;
   assign word      = ucode_rom(pc_ff);
   assign stall     = word.last && rsp_valid_ff && !rsp_ready;
   assign step      = busy_ff && !stall;

   always_comb begin
      case (word.cond)
         CND_NEVER:    jump = 1'b0;
         CND_ALWAYS:   jump = 1'b1;
         CND_TIMEOUT:  jump = status.timeout_over;
         CND_HOLD:     jump = status.hold;
         CND_BELOW:    jump = status.below;
         CND_DIV_BUSY: jump = status.div_busy;
         default:      jump = 1'b0;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (accept) begin
         busy_in = 1'b1;
         pc_in   = entry_addr(req_kind);
      end else if (step) begin
         if (word.last) begin
            busy_in = 1'b0;
         end else if (jump) begin
            pc_in = word.target;
         end else begin
            pc_in = pc_ff + 1'b1;
         end
      end
   end

   always_comb begin
      op = step ? word.op : OP_NOP;
   end

   always_comb begin
      if (step && word.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= A_PUB;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/reel_depth_controller_unit.sv =====
// ----------------------------------------------------------------------------
// Reel depth controller
// Winch reel controller driven by tick, click, limit-switch and PWM-edge words.
//
// req_chan takes one event word at a time; rsp_chan returns exactly one
// response word per event, carrying duties, direction, stop flag, event code,
// tick answer, depth and pulse width. csr_chan writes the eight settings
// registers by index and is always ready; write it only while idle.
// On the reel-up path of a tick word, the wrap parity comes from a
// 15-step divider that the sequencer loops on until it is done.
// A new event word is taken the cycle after the response is registered,
// while that response may still wait in the output register.
// If rsp_chan stalls with a response still held, the next event runs up to
// its publish step and holds there until the output register frees.
// Reset (synchronous) restores the register defaults and the reel state,
// with the stop flag set and nothing pending on either channel.
// ----------------------------------------------------------------------------
module reel_depth_controller_unit
   import rdc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   rdc_req_if.sink   req_chan,
   rdc_rsp_if.source rsp_chan,
   rdc_csr_if.sink   csr_chan
);

   dp_status_type status;
   rsp_word_type  rsp_word;
   op_type        op;
   logic          accept;
   logic          csr_write;

   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid;

   rdc_useq u_useq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_kind  (req_chan.req_type),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .accept    (accept),
      .op        (op)
   );

   rdc_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .target_click (req_chan.target_click),
      .switch_open  (req_chan.switch_open),
      .pin_level    (req_chan.pin_level),
      .timer_count  (req_chan.timer_count),
      .csr_write    (csr_write),
      .csr_index    (csr_chan.index),
      .csr_data     (csr_chan.data),
      .op           (op),
      .status       (status),
      .rsp_word     (rsp_word)
   );

   assign rsp_chan.motor_duty  = rsp_word.motor_duty;
   assign rsp_chan.wind_duty   = rsp_word.wind_duty;
   assign rsp_chan.direction   = rsp_word.direction;
   assign rsp_chan.all_stop    = rsp_word.all_stop;
   assign rsp_chan.event_code  = rsp_word.event_code;
   assign rsp_chan.tick_result = rsp_word.tick_result;
   assign rsp_chan.depth       = rsp_word.depth;
   assign rsp_chan.pulse_width = rsp_word.pulse_width;

endmodule
